>>> rtl/selection_text_utf8_packer_core_assert.svh
// ----------------------------------------------------------------------------
// selection_text_utf8_packer_core_assert
// Assertion macros used by stu8p_back, clocked on i_clk, held off by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef SELECTION_TEXT_UTF8_PACKER_CORE_ASSERT_SVH
`define SELECTION_TEXT_UTF8_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define STU8P_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STU8P_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/stu8p_pkg.sv
// ----------------------------------------------------------------------------
// stu8p_pkg
// Types and constants shared by the selection text packer modules.
// ----------------------------------------------------------------------------
package stu8p_pkg;

    localparam int MAX_ROW_CELLS = 256;
    localparam int CNT_W         = 9;
    localparam int CNT_MAX       = (1 << CNT_W) - 1;
    localparam int SPACE_LIMIT   = (MAX_ROW_CELLS < CNT_MAX) ? MAX_ROW_CELLS : CNT_MAX;
    localparam int CP_W          = 32;
    localparam int BYTE_W        = 8;
    localparam int MAX_RESULTS   = 5;
    localparam int MAX_CELL_B    = 4;
    localparam int RES_IDX_W     = 3;
    localparam int QUEUE_AW      = 1;
    localparam int QUEUE_DEPTH   = 1 << QUEUE_AW;

    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0d;
    localparam logic [CP_W-1:0]   SPACE_CP   = 32'h0000_0020;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [CNT_W-1:0]  repeat_count;
    } t_result;

    // One accepted cell, already expanded into its ordered results.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [RES_IDX_W-1:0]      n;
    } t_job;

endpackage

>>> rtl/stu8p_if.sv
// ----------------------------------------------------------------------------
// stu8p interfaces
// Valid/ready channels for cells in, bytes out and the mode register.
// ----------------------------------------------------------------------------
interface stu8p_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic        end_of_row;
    logic        end_of_selection;

    modport source (output valid, code_point, end_of_row, end_of_selection, input ready);
    modport sink (input valid, code_point, end_of_row, end_of_selection, output ready);
endinterface

interface stu8p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [8:0] repeat_count;
    logic       last_of_run;

    modport source (output valid, out_byte, repeat_count, last_of_run, input ready);
    modport sink (input valid, out_byte, repeat_count, last_of_run, output ready);
endinterface

interface stu8p_cfg_if;
    logic valid;
    logic ready;
    logic unicode_mode;

    modport source (output valid, unicode_mode, input ready);
    modport sink (input valid, unicode_mode, output ready);
endinterface

>>> rtl/selection_text_utf8_packer_core.sv
// ----------------------------------------------------------------------------
// selection_text_utf8_packer_core
// Packs selected screen cells into a UTF-8 or byte text stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one screen cell per item (code point, row end, selection end).
//   o_out carries one result per item: a byte, its repeat count and a flag on
//   the final result caused by a cell. A held space run leaves as one result.
//   i_cfg writes the unicode mode bit; it is always ready. The user must write
//   it only while the block is idle; the block itself does not enforce this.
// Timing:
//   A cell is classified and expanded in the cycle it is accepted; its first
//   result is registered onto o_out once it heads the job queue and the output
//   register is free. While o_out is ready the back end sends one result per
//   cycle, and a cell's result count (1 to 5, 0 for a held space) sets the rate.
//   The two-entry queue lets the front keep accepting while results drain.
// Reset: clears the held space count, the mode bit (byte mode), queue and output.
// Stall: when o_out is not ready the output holds, the queue fills, and then
//   i_in.ready drops until room frees.
// ----------------------------------------------------------------------------
module selection_text_utf8_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stu8p_in_if.sink    i_in,
    stu8p_cfg_if.sink   i_cfg,
    stu8p_out_if.source o_out
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    stu8p_pkg::t_job q_wr_job;
    stu8p_pkg::t_job q_rd_job;

    stu8p_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_wr_job)
    );

    stu8p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rd_job)
    );

    stu8p_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rd_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

>>> rtl/stu8p_front.sv
// ----------------------------------------------------------------------------
// stu8p_front
// Accepts cells, tracks the held space run and expands each cell into a job.
// ----------------------------------------------------------------------------
module stu8p_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stu8p_in_if.sink          i_in,
    stu8p_cfg_if.sink         i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output stu8p_pkg::t_job   o_job
);

    logic                                         r_unicode;
    logic [stu8p_pkg::CNT_W-1:0]                  r_pend;
    logic [stu8p_pkg::CNT_W-1:0]                  n_pend;
    logic [stu8p_pkg::CNT_W-1:0]                  pend_inc;
    logic [stu8p_pkg::MAX_CELL_B-1:0][7:0]        cb;
    logic [stu8p_pkg::RES_IDX_W-1:0]              nb;
    logic                                         is_space;
    logic                                         accept;
    logic [31:0]                                  cp;
    stu8p_pkg::t_job                              job;

    assign cp          = i_in.code_point;
    assign is_space    = (cp == stu8p_pkg::SPACE_CP);
    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;

    assign pend_inc = (r_pend < stu8p_pkg::CNT_W'(stu8p_pkg::SPACE_LIMIT))
                      ? r_pend + 1'b1 : r_pend;

    // Bytes of the cell itself.
    always_comb begin
        cb = '0;
        nb = '0;
        if (!r_unicode) begin
            cb[0] = cp[7:0];
            nb    = 3'd1;
        end else if (cp < 32'h80) begin
            cb[0] = cp[7:0];
            nb    = 3'd1;
        end else if (cp < 32'h800) begin
            cb[0] = 8'hc0 | {3'b0, cp[10:6]};
            cb[1] = 8'h80 | {2'b0, cp[5:0]};
            nb    = 3'd2;
        end else if (cp < 32'h1_0000) begin
            cb[0] = 8'he0 | {4'b0, cp[15:12]};
            cb[1] = 8'h80 | {2'b0, cp[11:6]};
            cb[2] = 8'h80 | {2'b0, cp[5:0]};
            nb    = 3'd3;
        end else if (cp < 32'h11_0000) begin
            cb[0] = 8'hf0 | {5'b0, cp[20:18]};
            cb[1] = 8'h80 | {2'b0, cp[17:12]};
            cb[2] = 8'h80 | {2'b0, cp[11:6]};
            cb[3] = 8'h80 | {2'b0, cp[5:0]};
            nb    = 3'd4;
        end else begin
            // out of range: replacement character
            cb[0] = 8'hef;
            cb[1] = 8'hbf;
            cb[2] = 8'hbd;
            nb    = 3'd3;
        end
    end

    // Order the results: held run, cell bytes, or a space's row/selection end result.
    always_comb begin
        job = '0;
        if (is_space) begin
            if (i_in.end_of_row) begin
                job.res[0] = '{out_byte: stu8p_pkg::CR_BYTE, repeat_count: 9'd1};
                job.n      = 3'd1;
            end else if (i_in.end_of_selection) begin
                job.res[0] = '{out_byte: stu8p_pkg::SPACE_BYTE, repeat_count: pend_inc};
                job.n      = 3'd1;
            end
        end else if (r_pend != '0) begin
            job.res[0] = '{out_byte: stu8p_pkg::SPACE_BYTE, repeat_count: r_pend};
            for (int i = 0; i < stu8p_pkg::MAX_CELL_B; i++) begin
                job.res[i+1] = '{out_byte: cb[i], repeat_count: 9'd1};
            end
            job.n = nb + 3'd1;
        end else begin
            for (int i = 0; i < stu8p_pkg::MAX_CELL_B; i++) begin
                job.res[i] = '{out_byte: cb[i], repeat_count: 9'd1};
            end
            job.n = nb;
        end
    end

    assign n_pend = (is_space && !i_in.end_of_row && !i_in.end_of_selection) ? pend_inc : '0;
    assign o_job  = job;
    assign o_push = accept && (job.n != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unicode <= 1'b0;
            r_pend    <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_unicode <= i_cfg.unicode_mode;
            end
            if (accept) begin
                r_pend <= n_pend;
            end
        end
    end

endmodule

>>> rtl/stu8p_queue.sv
// ----------------------------------------------------------------------------
// stu8p_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module stu8p_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stu8p_pkg::t_job i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output stu8p_pkg::t_job o_data
);

    stu8p_pkg::t_job                r_mem [stu8p_pkg::QUEUE_DEPTH];
    logic [stu8p_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [stu8p_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [stu8p_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (stu8p_pkg::QUEUE_AW+1)'(stu8p_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap naturally: depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/stu8p_back.sv
// ----------------------------------------------------------------------------
// stu8p_back
// Walks the head job one result per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
`include "selection_text_utf8_packer_core_assert.svh"

module stu8p_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  stu8p_pkg::t_job i_q_data,
    output logic            o_pop,
    stu8p_out_if.source     o_out
);

    logic                                r_out_valid;
    logic [7:0]                          r_out_byte;
    logic [stu8p_pkg::CNT_W-1:0]         r_out_count;
    logic                                r_out_last;
    logic [stu8p_pkg::RES_IDX_W-1:0]     r_idx;
    logic                                load;
    logic                                step;
    logic                                last;

    // Output register frees whenever it is empty or being taken.
    assign load  = !r_out_valid || o_out.ready;
    assign step  = i_q_valid && load;
    assign last  = (r_idx == i_q_data.n - 3'd1);
    assign o_pop = step && last;

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.repeat_count = r_out_count;
    assign o_out.last_of_run  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= i_q_valid;
            end
            if (step) begin
                r_idx <= last ? '0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte  <= i_q_data.res[r_idx].out_byte;
            r_out_count <= i_q_data.res[r_idx].repeat_count;
            r_out_last  <= last;
        end
    end

    `STU8P_ASSERT_NOW(a_idx_in_job, i_q_valid, r_idx < i_q_data.n, "index past job end")
    `STU8P_ASSERT_NOW(a_idx_idle, !i_q_valid, r_idx == '0, "index not rewound while empty")
    `STU8P_ASSERT_NXT(a_pop_marks_last, o_pop, r_out_valid && r_out_last, "pop without last")

endmodule
